// ----- rtl/core/limit_order_book_top_levels_core_assert.svh -----
// assertion macros shared by the order book core
`ifndef LIMIT_ORDER_BOOK_TOP_LEVELS_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_TOP_LEVELS_CORE_ASSERT_SVH

// same-cycle implication
`define LOBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lobt assertion failed");

// next-cycle implication
`define LOBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lobt assertion failed");

`endif

// ----- rtl/core/lobt_pkg.sv -----
// types, codes and defaults of the order book core
`default_nettype none
package lobt_pkg;

    localparam int MAX_ORDERS_DEF = 4096;
    localparam int MAX_LEVELS_DEF = 256;
    localparam int TOP_DEPTH_DEF  = 10;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_OTHER  = 2'd3;

    localparam logic signed [31:0] SIZE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] order_ref;
        logic        side;
        logic [31:0] price;
        logic [30:0] quantity;
        logic [63:0] timestamp;
    } in_t;

    typedef struct packed {
        logic [63:0]        stamp;
        logic               book_side;
        logic [3:0]         level_rank;
        logic               level_valid;
        logic [31:0]        level_price;
        logic signed [31:0] level_size;
        logic               overflow;
        logic               last;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
    } key_t;

    typedef struct packed {
        logic [31:0] price;
        logic [30:0] qty;
        logic        side;
    } det_t;

    typedef struct packed {
        logic [31:0]        price;
        logic signed [31:0] size;
    } lvl_t;

endpackage
`default_nettype wire

// ----- rtl/core/lobt_order_ram.sv -----
// order table memory: key and detail arrays, one read and one write port
`default_nettype none
module lobt_order_ram #(
    parameter int MAX_ORDERS = lobt_pkg::MAX_ORDERS_DEF,
    parameter int OW = $clog2(MAX_ORDERS)
) (
    input  wire logic           aclk,
    input  wire logic           rd_en,
    input  wire logic [OW-1:0]  rd_addr,
    output lobt_pkg::key_t      key_q,
    output lobt_pkg::det_t      det_q,
    input  wire logic           wr_key_en,
    input  wire logic           wr_det_en,
    input  wire logic [OW-1:0]  wr_addr,
    input  wire lobt_pkg::key_t wr_key,
    input  wire lobt_pkg::det_t wr_det
);

    lobt_pkg::key_t key_mem [MAX_ORDERS];
    lobt_pkg::det_t det_mem [MAX_ORDERS];

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            key_q <= key_mem[rd_addr];
            det_q <= det_mem[rd_addr];
        end
    end

    // write
    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_det_en) begin
            det_mem[wr_addr] <= wr_det;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lobt_level_ram.sv -----
// price level memory for both sides, addressed by side and rank
`default_nettype none
module lobt_level_ram #(
    parameter int AW = 9
) (
    input  wire logic           aclk,
    input  wire logic           rd_en,
    input  wire logic [AW-1:0]  rd_addr,
    output lobt_pkg::lvl_t      rd_q,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire lobt_pkg::lvl_t wr_data
);

    lobt_pkg::lvl_t mem [2**AW];

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    // write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/limit_order_book_top_levels_core.sv -----
// order book core: order table, sorted price levels and top-of-book snapshots
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_valid/s_ready  | s_data (lobt_pkg::in_t), one book event
//  m_      | out | m_valid/m_ready  | m_data (lobt_pkg::out_t), 2*TOP_DEPTH per event
//
// one event at a time; the order table search reads one entry a cycle (twice
// for a modify), the level search reads one level a cycle, the level shift
// moves the levels one place, and the snapshot reads a level and then loads
// the output register, waiting there while the output stalls.
// after reset a clearing pass marks all order slots free;
// s_ready stays low during it. m_ready low stalls only the snapshot.
`default_nettype none
`include "limit_order_book_top_levels_core_assert.svh"
module limit_order_book_top_levels_core #(
    parameter int MAX_ORDERS = lobt_pkg::MAX_ORDERS_DEF,
    parameter int MAX_LEVELS = lobt_pkg::MAX_LEVELS_DEF,
    parameter int TOP_DEPTH  = lobt_pkg::TOP_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lobt_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lobt_pkg::out_t     m_data
);

    localparam int OW = $clog2(MAX_ORDERS);
    localparam int LW = $clog2(MAX_LEVELS);
    localparam int RW = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
    localparam logic [OW:0] ORD_END   = (OW+1)'(MAX_ORDERS);
    localparam logic [OW:0] ORD_LAST  = (OW+1)'(MAX_ORDERS - 1);
    localparam logic [LW:0] CNT_MAX   = (LW+1)'(MAX_LEVELS);
    localparam logic [RW-1:0] RANK_LAST = RW'(TOP_DEPTH - 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_OSCAN = 4'd2;
    localparam logic [3:0] ST_CFREE = 4'd3;
    localparam logic [3:0] ST_LSCAN = 4'd4;
    localparam logic [3:0] ST_CUPD  = 4'd5;
    localparam logic [3:0] ST_SHIFT = 4'd6;
    localparam logic [3:0] ST_AFIN  = 4'd7;
    localparam logic [3:0] ST_SRD   = 4'd8;
    localparam logic [3:0] ST_SLD   = 4'd9;

    logic [3:0]         state_reg, state_next;
    lobt_pkg::in_t      in_reg, in_next;
    logic               add_reg, add_next;
    logic               ovf_reg, ovf_next;
    logic [OW:0]        clr_reg, clr_next;
    logic [OW:0]        oscan_reg, oscan_next;
    logic               opend_reg, opend_next;
    logic [OW-1:0]      opidx_reg, opidx_next;
    logic               hit_reg, hit_next;
    logic [OW-1:0]      hidx_reg, hidx_next;
    logic               free_reg, free_next;
    logic [OW-1:0]      fidx_reg, fidx_next;
    lobt_pkg::det_t     det_reg, det_next;
    logic               lside_reg, lside_next;
    logic [31:0]        lprice_reg, lprice_next;
    logic [LW:0]        lscan_reg, lscan_next;
    logic               lpend_reg, lpend_next;
    logic [LW-1:0]      lpidx_reg, lpidx_next;
    logic               found_reg, found_next;
    logic [LW:0]        pos_reg, pos_next;
    logic signed [31:0] lsize_reg, lsize_next;
    logic               shup_reg, shup_next;
    logic [LW:0]        shidx_reg, shidx_next;
    logic               spend_reg, spend_next;
    logic [LW-1:0]      spidx_reg, spidx_next;
    logic [LW:0]        bid_cnt_reg, bid_cnt_next;
    logic [LW:0]        ask_cnt_reg, ask_cnt_next;
    logic               sside_reg, sside_next;
    logic [RW-1:0]      rank_reg, rank_next;
    logic               m_valid_reg, m_valid_next;
    lobt_pkg::out_t     m_data_reg, m_data_next;

    logic               o_rd_en;
    logic [OW-1:0]      o_rd_addr;
    lobt_pkg::key_t     key_q;
    lobt_pkg::det_t     det_q;
    logic               o_wr_key_en, o_wr_det_en;
    logic [OW-1:0]      o_wr_addr;
    lobt_pkg::key_t     o_wr_key;
    lobt_pkg::det_t     o_wr_det;

    logic               l_rd_en;
    logic [LW:0]        l_rd_addr;
    lobt_pkg::lvl_t     lvl_q;
    logic               l_wr_en;
    logic [LW:0]        l_wr_addr;
    lobt_pkg::lvl_t     l_wr_data;

    logic               snap_load;

    lobt_order_ram #(
        .MAX_ORDERS (MAX_ORDERS),
        .OW         (OW)
    ) u_order_ram (
        .aclk      (aclk),
        .rd_en     (o_rd_en),
        .rd_addr   (o_rd_addr),
        .key_q     (key_q),
        .det_q     (det_q),
        .wr_key_en (o_wr_key_en),
        .wr_det_en (o_wr_det_en),
        .wr_addr   (o_wr_addr),
        .wr_key    (o_wr_key),
        .wr_det    (o_wr_det)
    );

    lobt_level_ram #(
        .AW (LW + 1)
    ) u_level_ram (
        .aclk    (aclk),
        .rd_en   (l_rd_en),
        .rd_addr (l_rd_addr),
        .rd_q    (lvl_q),
        .wr_en   (l_wr_en),
        .wr_addr (l_wr_addr),
        .wr_data (l_wr_data)
    );

    // event sequencer
    always_comb begin
        logic [LW:0]        cur_cnt;
        logic [LW:0]        snap_cnt;
        logic               better;
        logic               ldone, lfound;
        logic [LW:0]        lpos;
        logic               odone, ohit, ofree;
        logic signed [32:0] diff;
        logic signed [32:0] sum;
        logic               rank_ok;
        logic               go_lscan, go_oscan, go_snap, go_after_cancel;
        logic               lscan_side;
        logic [31:0]        lscan_price;

        state_next   = state_reg;
        in_next      = in_reg;
        add_next     = add_reg;
        ovf_next     = ovf_reg;
        clr_next     = clr_reg;
        oscan_next   = oscan_reg;
        opend_next   = 1'b0;
        opidx_next   = opidx_reg;
        hit_next     = hit_reg;
        hidx_next    = hidx_reg;
        free_next    = free_reg;
        fidx_next    = fidx_reg;
        det_next     = det_reg;
        lside_next   = lside_reg;
        lprice_next  = lprice_reg;
        lscan_next   = lscan_reg;
        lpend_next   = 1'b0;
        lpidx_next   = lpidx_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        lsize_next   = lsize_reg;
        shup_next    = shup_reg;
        shidx_next   = shidx_reg;
        spend_next   = 1'b0;
        spidx_next   = spidx_reg;
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        sside_next   = sside_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        o_rd_en     = 1'b0;
        o_rd_addr   = oscan_reg[OW-1:0];
        o_wr_key_en = 1'b0;
        o_wr_det_en = 1'b0;
        o_wr_addr   = clr_reg[OW-1:0];
        o_wr_key    = '0;
        o_wr_det    = '0;
        l_rd_en     = 1'b0;
        l_rd_addr   = '0;
        l_wr_en     = 1'b0;
        l_wr_addr   = '0;
        l_wr_data   = '0;
        s_ready     = 1'b0;
        snap_load   = 1'b0;

        cur_cnt  = lside_reg ? ask_cnt_reg : bid_cnt_reg;
        snap_cnt = sside_reg ? ask_cnt_reg : bid_cnt_reg;
        better   = lside_reg ? (lvl_q.price < lprice_reg) : (lvl_q.price > lprice_reg);
        ldone    = 1'b0;
        lfound   = 1'b0;
        lpos     = cur_cnt;
        odone    = 1'b0;
        ohit     = 1'b0;
        ofree    = free_reg;
        diff     = {lvl_q.size[31], lvl_q.size} - $signed({2'b00, det_reg.qty});
        sum      = {lsize_reg[31], lsize_reg} + $signed({2'b00, in_reg.quantity});
        rank_ok  = 32'(rank_reg) < 32'(snap_cnt);
        go_lscan = 1'b0;
        go_oscan = 1'b0;
        go_snap  = 1'b0;
        go_after_cancel = 1'b0;
        lscan_side  = in_reg.side;
        lscan_price = in_reg.price;

        unique case (state_reg)
            // mark every order slot free after reset
            ST_CLEAR: begin
                o_wr_key_en = 1'b1;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == ORD_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            // take the next event
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next  = s_data;
                    ovf_next = 1'b0;
                    unique case (s_data.opcode)
                        lobt_pkg::OP_ADD: begin
                            add_next    = 1'b1;
                            go_lscan    = 1'b1;
                            lscan_side  = s_data.side;
                            lscan_price = s_data.price;
                        end
                        lobt_pkg::OP_CANCEL, lobt_pkg::OP_MODIFY: begin
                            add_next = 1'b0;
                            go_oscan = 1'b1;
                        end
                        default: begin
                            go_snap = 1'b1;
                        end
                    endcase
                end
            end

            // search the order table, one key a cycle
            ST_OSCAN: begin
                if (oscan_reg < ORD_END) begin
                    o_rd_en    = 1'b1;
                    oscan_next = oscan_reg + 1'b1;
                    opend_next = 1'b1;
                    opidx_next = oscan_reg[OW-1:0];
                end
                if (opend_reg) begin
                    if (key_q.valid && key_q.id == in_reg.order_ref) begin
                        ohit      = 1'b1;
                        odone     = 1'b1;
                        hit_next  = 1'b1;
                        hidx_next = opidx_reg;
                        det_next  = det_q;
                    end else if (!key_q.valid && !free_reg) begin
                        ofree     = 1'b1;
                        free_next = 1'b1;
                        fidx_next = opidx_reg;
                    end
                end else if (oscan_reg >= ORD_END) begin
                    odone = 1'b1;
                end
                if (odone) begin
                    if (!add_reg) begin
                        if (ohit) begin
                            state_next = ST_CFREE;
                        end else begin
                            go_after_cancel = 1'b1;
                        end
                    end else if (ohit || ofree) begin
                        if (found_reg) begin
                            state_next = ST_AFIN;
                        end else begin
                            shup_next  = 1'b1;
                            shidx_next = cur_cnt;
                            state_next = ST_SHIFT;
                        end
                    end else begin
                        ovf_next = 1'b1;
                        go_snap  = 1'b1;
                    end
                end
            end

            // free the cancelled order, then look up its level
            ST_CFREE: begin
                o_wr_key_en = 1'b1;
                o_wr_addr   = hidx_reg;
                go_lscan    = 1'b1;
                lscan_side  = det_reg.side;
                lscan_price = det_reg.price;
            end

            // locate the price in the side's sorted levels
            ST_LSCAN: begin
                l_rd_addr = {lside_reg, lscan_reg[LW-1:0]};
                if (lscan_reg < cur_cnt) begin
                    l_rd_en    = 1'b1;
                    lscan_next = lscan_reg + 1'b1;
                    lpend_next = 1'b1;
                    lpidx_next = lscan_reg[LW-1:0];
                end
                if (lpend_reg) begin
                    if (!better) begin
                        ldone  = 1'b1;
                        lfound = (lvl_q.price == lprice_reg);
                        lpos   = {1'b0, lpidx_reg};
                    end
                end else if (lscan_reg >= cur_cnt) begin
                    ldone = 1'b1;
                end
                if (ldone) begin
                    found_next = lfound;
                    pos_next   = lpos;
                    lsize_next = lvl_q.size;
                    if (!add_reg) begin
                        if (!lfound) begin
                            go_after_cancel = 1'b1;
                        end else if (diff <= 33'sd0) begin
                            shup_next  = 1'b0;
                            shidx_next = lpos + 1'b1;
                            state_next = ST_SHIFT;
                        end else begin
                            lsize_next = diff[31:0];
                            state_next = ST_CUPD;
                        end
                    end else if (!lfound && cur_cnt >= CNT_MAX) begin
                        ovf_next = 1'b1;
                        go_snap  = 1'b1;
                    end else begin
                        go_oscan = 1'b1;
                    end
                end
            end

            // reduced level size after a cancel
            ST_CUPD: begin
                l_wr_en         = 1'b1;
                l_wr_addr       = {lside_reg, pos_reg[LW-1:0]};
                l_wr_data.price = lprice_reg;
                l_wr_data.size  = lsize_reg;
                go_after_cancel = 1'b1;
            end

            // move levels by one place, read one and write one a cycle
            ST_SHIFT: begin
                if (!shup_reg) begin
                    l_rd_addr = {lside_reg, shidx_reg[LW-1:0]};
                    if (shidx_reg < cur_cnt) begin
                        l_rd_en    = 1'b1;
                        shidx_next = shidx_reg + 1'b1;
                        spend_next = 1'b1;
                        spidx_next = shidx_reg[LW-1:0];
                    end
                    if (spend_reg) begin
                        l_wr_en   = 1'b1;
                        l_wr_addr = {lside_reg, spidx_reg - 1'b1};
                        l_wr_data = lvl_q;
                    end else if (shidx_reg >= cur_cnt) begin
                        if (lside_reg) begin
                            ask_cnt_next = ask_cnt_reg - 1'b1;
                        end else begin
                            bid_cnt_next = bid_cnt_reg - 1'b1;
                        end
                        go_after_cancel = 1'b1;
                    end
                end else begin
                    l_rd_addr = {lside_reg, LW'(shidx_reg - 1'b1)};
                    if (shidx_reg > pos_reg) begin
                        l_rd_en    = 1'b1;
                        shidx_next = shidx_reg - 1'b1;
                        spend_next = 1'b1;
                        spidx_next = LW'(shidx_reg - 1'b1);
                    end
                    if (spend_reg) begin
                        l_wr_en   = 1'b1;
                        l_wr_addr = {lside_reg, spidx_reg + 1'b1};
                        l_wr_data = lvl_q;
                    end else if (shidx_reg <= pos_reg) begin
                        state_next = ST_AFIN;
                    end
                end
            end

            // write the level and the order record of an add
            ST_AFIN: begin
                l_wr_en         = 1'b1;
                l_wr_addr       = {lside_reg, pos_reg[LW-1:0]};
                l_wr_data.price = in_reg.price;
                if (!found_reg) begin
                    l_wr_data.size = $signed({1'b0, in_reg.quantity});
                    if (lside_reg) begin
                        ask_cnt_next = ask_cnt_reg + 1'b1;
                    end else begin
                        bid_cnt_next = bid_cnt_reg + 1'b1;
                    end
                end else if (sum > 33'(lobt_pkg::SIZE_MAX)) begin
                    l_wr_data.size = lobt_pkg::SIZE_MAX;
                end else begin
                    l_wr_data.size = sum[31:0];
                end
                o_wr_key_en    = 1'b1;
                o_wr_det_en    = 1'b1;
                o_wr_addr      = hit_reg ? hidx_reg : fidx_reg;
                o_wr_key.valid = 1'b1;
                o_wr_key.id    = in_reg.order_ref;
                o_wr_det.price = in_reg.price;
                o_wr_det.qty   = in_reg.quantity;
                o_wr_det.side  = in_reg.side;
                go_snap        = 1'b1;
            end

            // snapshot: read one level
            ST_SRD: begin
                l_rd_en    = 1'b1;
                l_rd_addr  = {sside_reg, LW'(rank_reg)};
                state_next = ST_SLD;
            end

            // snapshot: load the output register once it is free
            ST_SLD: begin
                if (!m_valid_reg || m_ready) begin
                    snap_load               = 1'b1;
                    m_valid_next            = 1'b1;
                    m_data_next.stamp       = in_reg.timestamp;
                    m_data_next.book_side   = sside_reg;
                    m_data_next.level_rank  = 4'(rank_reg);
                    m_data_next.level_valid = rank_ok;
                    m_data_next.level_price = rank_ok ? lvl_q.price : 32'd0;
                    m_data_next.level_size  = rank_ok ? lvl_q.size : 32'sd0;
                    m_data_next.overflow    = ovf_reg;
                    m_data_next.last        = sside_reg && (rank_reg == RANK_LAST);
                    if (rank_reg == RANK_LAST) begin
                        rank_next = '0;
                        if (sside_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            sside_next = 1'b1;
                            state_next = ST_SRD;
                        end
                    end else begin
                        rank_next  = rank_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // after the cancel half: add of a modify, else snapshot
        if (go_after_cancel) begin
            if (in_reg.opcode == lobt_pkg::OP_MODIFY) begin
                add_next    = 1'b1;
                go_lscan    = 1'b1;
                lscan_side  = in_reg.side;
                lscan_price = in_reg.price;
            end else begin
                go_snap = 1'b1;
            end
        end

        if (go_lscan) begin
            lside_next  = lscan_side;
            lprice_next = lscan_price;
            lscan_next  = '0;
            lpend_next  = 1'b0;
            state_next  = ST_LSCAN;
        end
        if (go_oscan) begin
            oscan_next = '0;
            opend_next = 1'b0;
            hit_next   = 1'b0;
            free_next  = 1'b0;
            state_next = ST_OSCAN;
        end
        if (go_snap) begin
            sside_next = 1'b0;
            rank_next  = '0;
            state_next = ST_SRD;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            opend_reg   <= 1'b0;
            lpend_reg   <= 1'b0;
            spend_reg   <= 1'b0;
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            opend_reg   <= opend_next;
            lpend_reg   <= lpend_next;
            spend_reg   <= spend_next;
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        add_reg    <= add_next;
        ovf_reg    <= ovf_next;
        oscan_reg  <= oscan_next;
        opidx_reg  <= opidx_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        free_reg   <= free_next;
        fidx_reg   <= fidx_next;
        det_reg    <= det_next;
        lside_reg  <= lside_next;
        lprice_reg <= lprice_next;
        lscan_reg  <= lscan_next;
        lpidx_reg  <= lpidx_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        lsize_reg  <= lsize_next;
        shup_reg   <= shup_next;
        shidx_reg  <= shidx_next;
        spidx_reg  <= spidx_next;
        sside_reg  <= sside_next;
        rank_reg   <= rank_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LOBT_ASSERT_IMP(a_bid_cnt_bound, aclk, aresetn, 1'b1, bid_cnt_reg <= CNT_MAX)
    `LOBT_ASSERT_IMP(a_ask_cnt_bound, aclk, aresetn, 1'b1, ask_cnt_reg <= CNT_MAX)
    `LOBT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `LOBT_ASSERT_NXT(a_last_ends_event, aclk, aresetn, snap_load && m_data_next.last, state_reg == ST_IDLE)

endmodule
`default_nettype wire
